// ===== rtl/core/takf_pkg.sv =====
// Shared types, constants and helpers for the tilt angle Kalman filter.
package takf_pkg;

    localparam int COV_FRAC_BITS_DEF = 30;

    localparam logic [1:0] REG_TIME_STEP   = 2'd0;
    localparam logic [1:0] REG_ANGLE_NOISE = 2'd1;
    localparam logic [1:0] REG_BIAS_NOISE  = 2'd2;
    localparam logic [1:0] REG_MEAS_NOISE  = 2'd3;

    localparam logic [31:0] TIME_STEP_RST   = 32'd4294967;
    localparam logic [30:0] ANGLE_NOISE_RST = 31'd1073742;
    localparam logic [30:0] BIAS_NOISE_RST  = 31'd3221225;
    localparam logic [30:0] MEAS_NOISE_RST  = 31'd536870912;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LOAD,
        S_MUL_WRITE,
        S_DIV_INIT,
        S_DIV_RUN,
        S_DIV_DONE,
        S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_ANG_PRED,
        OP_P00_PRED,
        OP_P01_PRED,
        OP_P11_PRED,
        OP_P10_CORR,
        OP_P11_CORR,
        OP_P00_CORR,
        OP_P01_CORR,
        OP_ANG_CORR,
        OP_BIAS_CORR
    } t_mul_op;

    typedef struct packed {
        logic    capture;
        logic    mul_load;
        logic    mul_write;
        t_mul_op op;
        logic    div_init;
        logic    div_step;
        logic    div_finish;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > 38'sd2147483647) begin
            r = S32_MAX;
        end else if (v < -38'sd2147483648) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/takf_ctrl.sv =====
// Sequencing controller for the tilt angle Kalman filter.
module takf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  takf_pkg::t_status i_status,
    output takf_pkg::t_cmd    o_cmd
);

    takf_pkg::t_state  r_state, n_state;
    takf_pkg::t_mul_op r_op, n_op;
    logic [4:0]        r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= takf_pkg::S_IDLE;
            r_op    <= takf_pkg::OP_ANG_PRED;
            r_cnt   <= 5'd0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            takf_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) n_state = takf_pkg::S_MUL_LOAD;
            end
            takf_pkg::S_MUL_LOAD: n_state = takf_pkg::S_MUL_WRITE;
            takf_pkg::S_MUL_WRITE: begin
                if (r_op == takf_pkg::OP_P11_PRED) begin
                    n_state = takf_pkg::S_DIV_INIT;
                end else if (r_op == takf_pkg::OP_BIAS_CORR) begin
                    n_state = takf_pkg::S_FINISH;
                end else begin
                    n_state = takf_pkg::S_MUL_LOAD;
                end
            end
            takf_pkg::S_DIV_INIT: n_state = takf_pkg::S_DIV_RUN;
            takf_pkg::S_DIV_RUN: begin
                if (r_cnt == 5'd31) n_state = takf_pkg::S_DIV_DONE;
            end
            takf_pkg::S_DIV_DONE: n_state = takf_pkg::S_MUL_LOAD;
            takf_pkg::S_FINISH: begin
                if (i_status.out_free) n_state = takf_pkg::S_IDLE;
            end
            default: n_state = takf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_op  = r_op;
        n_cnt = 5'd0;
        case (r_state)
            takf_pkg::S_IDLE: n_op = takf_pkg::OP_ANG_PRED;
            takf_pkg::S_MUL_WRITE: begin
                if (r_op != takf_pkg::OP_BIAS_CORR) n_op = takf_pkg::t_mul_op'(r_op + 4'd1);
            end
            takf_pkg::S_DIV_RUN: n_cnt = r_cnt + 5'd1;
            default: n_op = r_op;
        endcase
    end

    always_comb begin
        o_s_axis_tready   = (r_state == takf_pkg::S_IDLE);
        o_cmd.capture    = (r_state == takf_pkg::S_IDLE) && i_s_axis_tvalid;
        o_cmd.mul_load   = (r_state == takf_pkg::S_MUL_LOAD);
        o_cmd.mul_write  = (r_state == takf_pkg::S_MUL_WRITE);
        o_cmd.op         = r_op;
        o_cmd.div_init   = (r_state == takf_pkg::S_DIV_INIT);
        o_cmd.div_step   = (r_state == takf_pkg::S_DIV_RUN);
        o_cmd.div_finish = (r_state == takf_pkg::S_DIV_DONE);
        o_cmd.out_load   = (r_state == takf_pkg::S_FINISH) && i_status.out_free;
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == takf_pkg::S_MUL_LOAD) && (r_op == takf_pkg::OP_ANG_PRED))
        else $error("capture did not start prediction");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_finish |-> $past(o_cmd.div_step) && $past(r_cnt) == 5'd31)
        else $error("division ended early");
    a_corr_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_finish |=> r_op == takf_pkg::OP_P10_CORR)
        else $error("correction started on wrong op");
`endif

endmodule

// ===== rtl/core/takf_datapath.sv =====
// Datapath of the tilt angle Kalman filter: state, shared multiplier, divider.
module takf_datapath #(
    parameter int COV_FRAC_BITS = takf_pkg::COV_FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_addr,
    input  logic [31:0]       i_cfg_data,
    input  logic [63:0]       i_s_axis_tdata,
    input  logic              i_m_axis_tready,
    output logic              o_m_axis_tvalid,
    output logic [63:0]       o_m_axis_tdata,
    input  takf_pkg::t_cmd    i_cmd,
    output takf_pkg::t_status o_status
);

    localparam int DW = 32 + COV_FRAC_BITS;
    localparam logic [67:0] RND_32  = 68'd1 << 31;
    localparam logic [67:0] RND_COV = 68'd1 << (COV_FRAC_BITS - 1);

    logic [31:0] r_dt;
    logic [30:0] r_qa, r_qb, r_r;
    logic signed [31:0] r_ang, r_bias, r_p00, r_p01, r_p10, r_p11;
    logic signed [31:0] r_meas, r_gyro, r_k0, r_k1;
    logic signed [32:0] r_err;
    logic [66:0] r_prod;
    logic        r_neg, r_sh_cov;
    logic [32:0] r_e;
    logic        r_gain_zero, r_ovf0, r_ovf1, r_sgn0, r_sgn1;
    logic [33:0] r_rem0, r_rem1;
    logic [31:0] r_lo0, r_lo1, r_q0, r_q1;
    logic        r_out_valid;
    logic [63:0] r_out_data;

    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic               sh_cov;
    logic [33:0]        mag_a;
    logic [32:0]        mag_b;
    logic [67:0]        rsum, scaled;
    logic signed [37:0] m38;
    logic signed [33:0] e_s;
    logic [31:0]        mag_p00, mag_p10;
    logic [DW-1:0]      d0, d1;
    logic [33:0]        t0, t1, e_ext;
    logic               ge0, ge1;

    function automatic logic signed [31:0] gain(input logic sgn, input logic ovf,
                                                input logic [31:0] q);
        logic signed [31:0] g;
        if (ovf) begin
            g = sgn ? takf_pkg::S32_MIN : takf_pkg::S32_MAX;
        end else if (sgn) begin
            g = (q > 32'h8000_0000) ? takf_pkg::S32_MIN : $signed(32'd0 - q);
        end else begin
            g = (q > 32'h7FFF_FFFF) ? takf_pkg::S32_MAX : $signed(q);
        end
        return g;
    endfunction

    always_comb begin
        mul_a  = 34'sd0;
        mul_b  = $signed({1'b0, r_dt});
        sh_cov = 1'b1;
        case (i_cmd.op)
            takf_pkg::OP_ANG_PRED: begin
                mul_a  = 34'(r_gyro) - 34'(r_bias);
                sh_cov = 1'b0;
            end
            takf_pkg::OP_P00_PRED: begin
                mul_a  = $signed({3'b000, r_qa}) - 34'(r_p01) - 34'(r_p10);
                sh_cov = 1'b0;
            end
            takf_pkg::OP_P01_PRED: begin
                mul_a  = 34'(r_p11);
                sh_cov = 1'b0;
            end
            takf_pkg::OP_P11_PRED: begin
                mul_a  = $signed({3'b000, r_qb});
                sh_cov = 1'b0;
            end
            takf_pkg::OP_P10_CORR: begin mul_a = 34'(r_k1); mul_b = 33'(r_p00); end
            takf_pkg::OP_P11_CORR: begin mul_a = 34'(r_k1); mul_b = 33'(r_p01); end
            takf_pkg::OP_P00_CORR: begin mul_a = 34'(r_k0); mul_b = 33'(r_p00); end
            takf_pkg::OP_P01_CORR: begin mul_a = 34'(r_k0); mul_b = 33'(r_p01); end
            takf_pkg::OP_ANG_CORR: begin mul_a = 34'(r_k0); mul_b = r_err; end
            takf_pkg::OP_BIAS_CORR: begin mul_a = 34'(r_k1); mul_b = r_err; end
            default: mul_a = 34'sd0;
        endcase
        mag_a = mul_a[33] ? 34'(-mul_a) : 34'(mul_a);
        mag_b = mul_b[32] ? 33'(-mul_b) : 33'(mul_b);
    end

    always_comb begin
        rsum   = {1'b0, r_prod} + (r_sh_cov ? RND_COV : RND_32);
        scaled = r_sh_cov ? (rsum >> COV_FRAC_BITS) : (rsum >> 32);
        m38    = r_neg ? -$signed({2'b00, scaled[35:0]}) : $signed({2'b00, scaled[35:0]});
    end

    always_comb begin
        e_s     = $signed({3'b000, r_r}) + 34'(r_p00);
        mag_p00 = r_p00[31] ? 32'(-r_p00) : 32'(r_p00);
        mag_p10 = r_p10[31] ? 32'(-r_p10) : 32'(r_p10);
        d0      = {mag_p00, {COV_FRAC_BITS{1'b0}}};
        d1      = {mag_p10, {COV_FRAC_BITS{1'b0}}};
        e_ext   = {1'b0, r_e};
        t0      = {r_rem0[32:0], r_lo0[31]};
        t1      = {r_rem1[32:0], r_lo1[31]};
        ge0     = t0 >= e_ext;
        ge1     = t1 >= e_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= takf_pkg::TIME_STEP_RST;
            r_qa <= takf_pkg::ANGLE_NOISE_RST;
            r_qb <= takf_pkg::BIAS_NOISE_RST;
            r_r  <= takf_pkg::MEAS_NOISE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                takf_pkg::REG_TIME_STEP:   r_dt <= i_cfg_data;
                takf_pkg::REG_ANGLE_NOISE: r_qa <= i_cfg_data[30:0];
                takf_pkg::REG_BIAS_NOISE:  r_qb <= i_cfg_data[30:0];
                takf_pkg::REG_MEAS_NOISE:  r_r  <= i_cfg_data[30:0];
                default: r_dt <= r_dt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang  <= 32'sd0;
            r_bias <= 32'sd0;
            r_p00  <= 32'sd1 <<< COV_FRAC_BITS;
            r_p01  <= 32'sd0;
            r_p10  <= 32'sd0;
            r_p11  <= 32'sd1 <<< COV_FRAC_BITS;
        end else if (i_cmd.mul_write) begin
            case (i_cmd.op)
                takf_pkg::OP_ANG_PRED: r_ang <= takf_pkg::sat32(38'(r_ang) + m38);
                takf_pkg::OP_P00_PRED: r_p00 <= takf_pkg::sat32(38'(r_p00) + m38);
                takf_pkg::OP_P01_PRED: begin
                    r_p01 <= takf_pkg::sat32(38'(r_p01) - m38);
                    r_p10 <= takf_pkg::sat32(38'(r_p10) - m38);
                end
                takf_pkg::OP_P11_PRED:  r_p11  <= takf_pkg::sat32(38'(r_p11) + m38);
                takf_pkg::OP_P10_CORR:  r_p10  <= takf_pkg::sat32(38'(r_p10) - m38);
                takf_pkg::OP_P11_CORR:  r_p11  <= takf_pkg::sat32(38'(r_p11) - m38);
                takf_pkg::OP_P00_CORR:  r_p00  <= takf_pkg::sat32(38'(r_p00) - m38);
                takf_pkg::OP_P01_CORR:  r_p01  <= takf_pkg::sat32(38'(r_p01) - m38);
                takf_pkg::OP_ANG_CORR:  r_ang  <= takf_pkg::sat32(38'(r_ang) + m38);
                takf_pkg::OP_BIAS_CORR: r_bias <= takf_pkg::sat32(38'(r_bias) + m38);
                default: r_ang <= r_ang;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_meas <= $signed(i_s_axis_tdata[31:0]);
            r_gyro <= $signed(i_s_axis_tdata[63:32]);
        end
        if (i_cmd.mul_load) begin
            r_prod   <= 67'(mag_a) * 67'(mag_b);
            r_neg    <= mul_a[33] ^ mul_b[32];
            r_sh_cov <= sh_cov;
        end
        if (i_cmd.div_init) begin
            r_err       <= 33'(r_meas) - 33'(r_ang);
            r_e         <= e_s[32:0];
            r_gain_zero <= (e_s <= 34'sd0);
            r_sgn0      <= r_p00[31];
            r_sgn1      <= r_p10[31];
            r_rem0      <= 34'(d0 >> 32);
            r_rem1      <= 34'(d1 >> 32);
            r_ovf0      <= 34'(d0 >> 32) >= {1'b0, e_s[32:0]};
            r_ovf1      <= 34'(d1 >> 32) >= {1'b0, e_s[32:0]};
            r_lo0       <= d0[31:0];
            r_lo1       <= d1[31:0];
        end
        if (i_cmd.div_step) begin
            r_rem0 <= ge0 ? t0 - e_ext : t0;
            r_rem1 <= ge1 ? t1 - e_ext : t1;
            r_q0   <= {r_q0[30:0], ge0};
            r_q1   <= {r_q1[30:0], ge1};
            r_lo0  <= {r_lo0[30:0], 1'b0};
            r_lo1  <= {r_lo1[30:0], 1'b0};
        end
        if (i_cmd.div_finish) begin
            r_k0 <= r_gain_zero ? 32'sd0 : gain(r_sgn0, r_ovf0, r_q0);
            r_k1 <= r_gain_zero ? 32'sd0 : gain(r_sgn1, r_ovf1, r_q1);
        end
        if (i_cmd.out_load) begin
            r_out_data <= {takf_pkg::sat32(38'(r_gyro) - 38'(r_bias)), r_ang};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.out_load && r_out_valid && !i_m_axis_tready))
        else $error("result overwritten before transfer");
    a_out_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("result not presented");
    a_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_finish && r_gain_zero |=> r_k0 == 32'sd0 && r_k1 == 32'sd0)
        else $error("gain not cleared for non-positive variance");
`endif

endmodule

// ===== rtl/core/tilt_angle_kalman_filter_unit.sv =====
// A 32-step restoring divider and one shared multiplier compute each item; a new
// item is taken only after the previous one has been finished.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) restores default registers, zero angle and bias,
// and unit diagonal covariance.
module tilt_angle_kalman_filter_unit #(
    parameter int COV_FRAC_BITS = takf_pkg::COV_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // measured_angle[31:0], measured_rate[63:32]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata    // fused_angle[31:0], corrected_rate[63:32]
);

    takf_pkg::t_cmd    cmd;
    takf_pkg::t_status status;

    takf_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    takf_datapath #(
        .COV_FRAC_BITS (COV_FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cmd           (cmd),
        .o_status        (status)
    );

endmodule
